// ----- hw/rtl/sobel_edge_magnitude_unit_assert.svh -----
// Assertion macros for the Sobel edge magnitude unit.
// Included by the top level; the macros use its clk and arst_n.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SEM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SEM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/sem_pkg.sv -----
// Shared types and constants for the Sobel edge magnitude unit.
// No dependencies; used by every module of the block.
`default_nettype none

package sem_pkg;

	localparam int MAX_LINE     = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int PIX_W        = 8;
	localparam int CFG_W        = 13;
	localparam int IDX_W        = 2;
	localparam int COL_W        = $clog2(MAX_LINE);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int DIM_W        = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;

	localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = CFG_W'(640);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} column_t;

	typedef struct packed {
		column_t left;
		column_t center;
		column_t right;
	} window_t;

	// Line memory word: pixel two rows up, pixel one row up.
	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
	} line_pair_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sobel_edge_magnitude_unit.sv -----
// Pipeline: stage 1 (pixel, line memory read), then window and stage 2, then
// the output register. Throughput: one pixel per clock unless the output stalls,
// set by one memory read and write-back per cycle; border pixels give no result.
// Reset: counters and window cleared, line_width 640, frame_height 480;
// the line memory is not cleared (every entry is written before it is used).
`default_nettype none

`include "sobel_edge_magnitude_unit_assert.svh"

module sobel_edge_magnitude_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sem_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [sem_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        pixel_valid,
	output logic                             pixel_ready,
	input  wire logic [sem_pkg::PIX_W-1:0]   pixel,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output logic [sem_pkg::PIX_W-1:0]        edge_magnitude,
	output logic                             frame_last
);

	localparam int DW = sem_pkg::DIM_W;

	logic [sem_pkg::CFG_W-1:0] line_width_q, frame_height_q;
	logic [DW-1:0]             w_eff, h_eff;
	logic [sem_pkg::COL_W-1:0] col_q;
	logic [sem_pkg::ROW_W-1:0] row_q;
	logic [DW-1:0]             col_inc, row_inc;
	logic                      in_acc, cfg_hit, prod, last;

	logic                      v_s1, prod_s1, last_s1;
	logic [sem_pkg::PIX_W-1:0] pix_s1;
	logic [sem_pkg::COL_W-1:0] col_s1;
	logic                      v_s2, prod_s2, last_s2;
	sem_pkg::window_t          window_q;

	logic                      result_valid_q, frame_last_q;
	logic [sem_pkg::PIX_W-1:0] edge_magnitude_q;
	logic [sem_pkg::PIX_W-1:0] mag;

	logic                      out_free, s2_free, s2_out, s1_adv;
	sem_pkg::line_pair_t       rd_pair, wr_pair;

	assign in_acc  = pixel_valid && pixel_ready;
	assign cfg_hit = cfg_we && (cfg_index == sem_pkg::REG_LINE_WIDTH ||
	                            cfg_index == sem_pkg::REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= sem_pkg::LINE_WIDTH_RST;
			frame_height_q <= sem_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sem_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data;
				sem_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp frame size to 3..max
	always_comb begin
		if (DW'(line_width_q) < DW'(3)) begin
			w_eff = DW'(3);
		end else if (DW'(line_width_q) > DW'(sem_pkg::MAX_LINE)) begin
			w_eff = DW'(sem_pkg::MAX_LINE);
		end else begin
			w_eff = DW'(line_width_q);
		end
		if (DW'(frame_height_q) < DW'(3)) begin
			h_eff = DW'(3);
		end else if (DW'(frame_height_q) > DW'(sem_pkg::HEIGHT_LIMIT)) begin
			h_eff = DW'(sem_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = DW'(frame_height_q);
		end
	end

	assign col_inc = DW'(col_q) + DW'(1);
	assign row_inc = DW'(row_q) + DW'(1);
	assign prod    = (row_q >= sem_pkg::ROW_W'(2)) && (col_q >= sem_pkg::COL_W'(2));
	assign last    = (DW'(row_q) == h_eff - DW'(1)) && (DW'(col_q) == w_eff - DW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[sem_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[sem_pkg::COL_W-1:0];
			end
		end
	end

	// pipeline handshake
	assign out_free    = !result_valid_q || result_ready;
	assign s2_out      = v_s2 && prod_s2 && out_free;
	assign s2_free     = !v_s2 || !prod_s2 || out_free;
	assign s1_adv      = v_s1 && s2_free;
	assign pixel_ready = !v_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pixel;
			col_s1  <= col_q;
			prod_s1 <= prod;
			last_s1 <= last;
		end
	end

	sem_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_pair),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (wr_pair)
	);

	// row shift on write-back: middle moves up, new pixel becomes middle
	assign wr_pair.upper  = rd_pair.middle;
	assign wr_pair.middle = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_hit) begin
			window_q <= '0;
		end else if (s1_adv) begin
			window_q.left       <= window_q.center;
			window_q.center     <= window_q.right;
			window_q.right.top  <= rd_pair.upper;
			window_q.right.mid  <= rd_pair.middle;
			window_q.right.bot  <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv) begin
			v_s2 <= 1'b1;
		end else if (s2_free) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			prod_s2 <= prod_s1;
			last_s2 <= last_s1;
		end
	end

	sem_grad u_grad (
		.win (window_q),
		.mag (mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s2_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_out) begin
			edge_magnitude_q <= mag;
			frame_last_q     <= last_s2;
		end
	end

	assign result_valid   = result_valid_q;
	assign edge_magnitude = edge_magnitude_q;
	assign frame_last     = frame_last_q;

	`SEM_ASSERT_IMP(a_no_rmw_overlap, in_acc && v_s1, col_q != col_s1, "read hits pending write-back")
	`SEM_ASSERT_IMP(a_col_in_range, 1'b1, DW'(col_q) < w_eff, "column counter past line width")
	`SEM_ASSERT_NXT(a_accept_loads_s1, in_acc, v_s1 && col_s1 == $past(col_q), "stage 1 not loaded")

endmodule

`default_nettype wire

// ----- hw/rtl/sem_line_mem.sv -----
// Line memory for the Sobel unit: two previous rows packed in one word.
// Depends on sem_pkg. One read and one write port, registered read data.
`default_nettype none

module sem_line_mem (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [sem_pkg::COL_W-1:0] rd_addr,
	output sem_pkg::line_pair_t           rd_data,
	input  wire logic                     wr_en,
	input  wire logic [sem_pkg::COL_W-1:0] wr_addr,
	input  wire sem_pkg::line_pair_t      wr_data
);

	sem_pkg::line_pair_t mem [sem_pkg::MAX_LINE];
	sem_pkg::line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sem_grad.sv -----
// Sobel gradient and saturated L1 magnitude over a 3x3 window.
// Depends on sem_pkg for the window type.
`default_nettype none

module sem_grad (
	input  wire sem_pkg::window_t            win,
	output logic [sem_pkg::PIX_W-1:0]        mag
);

	localparam int GW = sem_pkg::PIX_W + 3;

	logic signed [GW-1:0] gx, gy;
	logic        [GW-2:0] ax, ay;
	logic        [GW-1:0] sum;

	function automatic logic signed [GW-1:0] ext1(input logic [sem_pkg::PIX_W-1:0] p);
		return $signed({3'b000, p});
	endfunction

	function automatic logic signed [GW-1:0] ext2(input logic [sem_pkg::PIX_W-1:0] p);
		return $signed({2'b00, p, 1'b0});
	endfunction

	always_comb begin
		gx = (ext1(win.right.top) - ext1(win.left.top))
		   + (ext2(win.right.mid) - ext2(win.left.mid))
		   + (ext1(win.right.bot) - ext1(win.left.bot));
		gy = (ext1(win.left.bot) - ext1(win.left.top))
		   + (ext2(win.center.bot) - ext2(win.center.top))
		   + (ext1(win.right.bot) - ext1(win.right.top));
		ax  = gx[GW-1] ? (GW-1)'(-gx) : gx[GW-2:0];
		ay  = gy[GW-1] ? (GW-1)'(-gy) : gy[GW-2:0];
		sum = {1'b0, ax} + {1'b0, ay};
		if (sum > GW'(255)) begin
			mag = '1;
		end else begin
			mag = sum[sem_pkg::PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire
